### design/cms_pkg.sv
`default_nettype none

package cms_pkg;

    localparam int OPEN_LEN   = 9;
    localparam int CLOSE_LEN  = 3;
    localparam int HELD_DEPTH = 8;
    localparam int WIN_LEN    = HELD_DEPTH + 1;
    localparam int Q_DEPTH    = 16;

    localparam logic [7:0] OPEN_PAT [OPEN_LEN] = '{
        8'h3C, 8'h21, 8'h5B, 8'h63, 8'h64, 8'h61, 8'h74, 8'h61, 8'h5B
    };
    localparam logic [7:0] CLOSE_PAT [CLOSE_LEN] = '{8'h5D, 8'h5D, 8'h3E};

    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       run_last;
        logic       stream_end;
    } t_beat;

    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        if (c >= UPPER_A && c <= UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### design/cdata_marker_stripper_unit.sv
`default_nettype none

// channel   dir  tdata             tlast           tuser
// s_axis    in   [7:0] in_byte     end_of_stream   -
// m_axis    out  [7:0] out_byte    run_last        [0] has_byte, [1] stream_end
//
// One input beat per cycle while s_axis_tready is high; the beat is matched against both
// markers in the cycle it is taken and its results go to a 16-entry output queue.
// Each input beat yields 0 to 9 output beats, drained one per cycle while m_axis_tready is high.
// s_axis_tready is high while at most 7 queue entries are in use, so a burst of
// flushed held bytes can stall the input.
// Reset (synchronous, active low) empties the queue, the held bytes and the
// section flag.

module cdata_marker_stripper_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic       i_s_axis_tlast,
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic      [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic            o_m_axis_tlast,
    output logic      [1:0] o_m_axis_tuser    // [0] has_byte, [1] stream_end
);

    localparam int QW = $clog2(cms_pkg::Q_DEPTH + 1);

    logic [7:0]      r_held [cms_pkg::HELD_DEPTH];
    logic [7:0]      n_held [cms_pkg::HELD_DEPTH];
    logic [3:0]      r_held_cnt, n_held_cnt;
    logic            r_inside, n_inside;
    cms_pkg::t_beat  r_q [cms_pkg::Q_DEPTH];
    cms_pkg::t_beat  n_q [cms_pkg::Q_DEPTH];
    logic [QW-1:0]   r_occ, n_occ;

    logic [7:0]      w_win [cms_pkg::WIN_LEN];
    logic [3:0]      w_n;
    logic [cms_pkg::WIN_LEN-1:0] w_open_ok, w_close_ok;
    logic [3:0]      w_k, w_ne, w_pc;
    logic            w_done, w_notice, w_acc, w_pop, w_eos;
    logic [QW-1:0]   w_base;
    cms_pkg::t_beat  w_push [cms_pkg::WIN_LEN];

    assign w_eos = i_s_axis_tlast;
    assign w_n   = r_held_cnt + 4'd1;
    assign w_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_pop = (r_occ != '0) && i_m_axis_tready;

    assign o_s_axis_tready = r_occ <= QW'(cms_pkg::Q_DEPTH - cms_pkg::WIN_LEN);
    assign o_m_axis_tvalid = r_occ != '0;
    assign o_m_axis_tdata  = r_q[0].data;
    assign o_m_axis_tlast  = r_q[0].run_last;
    assign o_m_axis_tuser  = {r_q[0].stream_end, r_q[0].has_byte};

    // window: held bytes followed by the new byte
    always_comb begin
        for (int i = 0; i < cms_pkg::WIN_LEN; i++) begin
            w_win[i] = i_s_axis_tdata;
            if (i < cms_pkg::HELD_DEPTH) begin
                if (4'(i) < r_held_cnt) begin
                    w_win[i] = r_held[3'(i)];
                end
            end
        end
    end

    // test every suffix of the window against both markers
    always_comb begin
        for (int k = 0; k < cms_pkg::WIN_LEN; k++) begin
            w_open_ok[k]  = 4'(k) < w_n;
            w_close_ok[k] = r_inside && (4'(k) < w_n) && (5'(k + cms_pkg::CLOSE_LEN) >= {1'b0, w_n});
            for (int j = 0; j < cms_pkg::OPEN_LEN; j++) begin
                if (k + j < cms_pkg::WIN_LEN) begin
                    if (5'(k + j) < {1'b0, w_n}) begin
                        if (cms_pkg::fold_byte(w_win[k + j]) != cms_pkg::OPEN_PAT[j]) begin
                            w_open_ok[k] = 1'b0;
                        end
                        if (j < cms_pkg::CLOSE_LEN) begin
                            if (w_win[k + j] != cms_pkg::CLOSE_PAT[j]) begin
                                w_close_ok[k] = 1'b0;
                            end
                        end
                    end
                end
            end
        end
    end

    // leftmost surviving suffix
    always_comb begin
        w_k    = w_n;
        w_done = 1'b0;
        for (int k = cms_pkg::WIN_LEN - 1; k >= 0; k--) begin
            if (w_open_ok[k] || w_close_ok[k]) begin
                w_k    = 4'(k);
                w_done = (w_open_ok[k] && (w_n == 4'(cms_pkg::OPEN_LEN)) && (k == 0))
                      || (w_close_ok[k] && (w_n - 4'(k) == 4'(cms_pkg::CLOSE_LEN)));
            end
        end
        w_ne     = (w_eos && !w_done) ? w_n : w_k;
        w_notice = w_eos && (w_ne == 4'd0);
        w_pc     = w_notice ? 4'd1 : w_ne;
    end

    always_comb begin
        for (int m = 0; m < cms_pkg::WIN_LEN; m++) begin
            w_push[m].data       = w_notice ? 8'h00 : w_win[m];
            w_push[m].has_byte   = !w_notice;
            w_push[m].run_last   = 4'(m + 1) == w_pc;
            w_push[m].stream_end = (4'(m + 1) == w_pc) && w_eos;
        end
    end

    // held bytes and section flag
    always_comb begin
        n_held     = r_held;
        n_held_cnt = r_held_cnt;
        n_inside   = r_inside;
        if (w_acc) begin
            for (int j = 0; j < cms_pkg::HELD_DEPTH; j++) begin
                for (int m = 0; m < cms_pkg::WIN_LEN; m++) begin
                    if (5'(m) == {1'b0, w_k} + 5'(j)) begin
                        n_held[j] = w_win[m];
                    end
                end
            end
            if (w_eos) begin
                n_held_cnt = 4'd0;
                n_inside   = 1'b0;
            end else if (w_done) begin
                n_held_cnt = 4'd0;
                n_inside   = w_k == 4'd0 && w_open_ok[0];
            end else begin
                n_held_cnt = w_n - w_k;
            end
        end
    end

    // output queue: shift on pop, append results behind the survivors
    always_comb begin
        w_base = r_occ - QW'(w_pop);
        n_occ  = w_base + (w_acc ? QW'(w_pc) : QW'(0));
        for (int i = 0; i < cms_pkg::Q_DEPTH; i++) begin
            n_q[i] = r_q[i];
            if (QW'(i) < w_base) begin
                if (w_pop && (i + 1 < cms_pkg::Q_DEPTH)) begin
                    n_q[i] = r_q[(i + 1) % cms_pkg::Q_DEPTH];
                end
            end else if (w_acc) begin
                for (int m = 0; m < cms_pkg::WIN_LEN; m++) begin
                    if ((QW'(i) == w_base + QW'(m)) && (4'(m) < w_pc)) begin
                        n_q[i] = w_push[m];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= 4'd0;
            r_inside   <= 1'b0;
            r_occ      <= '0;
        end else begin
            r_held_cnt <= n_held_cnt;
            r_inside   <= n_inside;
            r_occ      <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        r_q    <= n_q;
    end

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= QW'(cms_pkg::Q_DEPTH))
        else $error("output queue overflow");

    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_cnt <= 4'(cms_pkg::HELD_DEPTH))
        else $error("held count out of range");

    a_held_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_cnt != 4'd0 |->
            (r_held[0] == cms_pkg::OPEN_PAT[0]) ||
            (r_inside && r_held[0] == cms_pkg::CLOSE_PAT[0]))
        else $error("held bytes do not start a marker");

    a_eos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_s_axis_tlast |=> (r_held_cnt == 4'd0) && !r_inside)
        else $error("state not cleared after end of stream");

    a_notice_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tlast && o_m_axis_tuser[1])
        else $error("bare end notice without end flags");

endmodule

`default_nettype wire

### tb/sv/cdata_marker_stripper_unit_tb.sv
`default_nettype none

class cdata_strip_tracker;

    logic [7:0]      held [cms_pkg::HELD_DEPTH];
    int              held_n;
    bit              in_section;
    logic [7:0]      scan [cms_pkg::WIN_LEN];
    cms_pkg::t_beat  out_beats_due[$];
    int              errors;

    function new();
        held_n     = 0;
        in_section = 0;
        errors     = 0;
    endfunction

    function automatic logic [7:0] lower_case(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
    endfunction

    function automatic bit opens_marker(int n);
        if (n > cms_pkg::OPEN_LEN) begin
            return 0;
        end
        for (int i = 0; i < n; i++) begin
            if (lower_case(scan[i]) != cms_pkg::OPEN_PAT[i]) begin
                return 0;
            end
        end
        return 1;
    endfunction

    function automatic bit closes_marker(int n);
        if (n > cms_pkg::CLOSE_LEN) begin
            return 0;
        end
        for (int i = 0; i < n; i++) begin
            if (scan[i] != cms_pkg::CLOSE_PAT[i]) begin
                return 0;
            end
        end
        return 1;
    endfunction

    function automatic int pending();
        return out_beats_due.size();
    endfunction

    // predict the beats released by one accepted input byte
    function automatic void take_byte(logic [7:0] b, logic eos);
        logic [7:0]     passed[$];
        int             n;
        cms_pkg::t_beat r;
        for (int i = 0; i < held_n; i++) begin
            scan[i] = held[i];
        end
        scan[held_n] = b;
        n = held_n + 1;
        while (n > 0) begin
            if (opens_marker(n)) begin
                if (n == cms_pkg::OPEN_LEN) begin
                    n = 0;
                    in_section = 1;
                end
                break;
            end
            if (in_section && closes_marker(n)) begin
                if (n == cms_pkg::CLOSE_LEN) begin
                    n = 0;
                    in_section = 0;
                end
                break;
            end
            passed.push_back(scan[0]);
            for (int i = 0; i < n - 1; i++) begin
                scan[i] = scan[i + 1];
            end
            n--;
        end
        if (eos) begin
            for (int i = 0; i < n; i++) begin
                passed.push_back(scan[i]);
            end
            n = 0;
            in_section = 0;
        end
        for (int i = 0; i < n; i++) begin
            held[i] = scan[i];
        end
        held_n = n;
        if (passed.size() == 0) begin
            if (eos) begin
                r.data       = 8'h00;
                r.has_byte   = 1'b0;
                r.run_last   = 1'b1;
                r.stream_end = 1'b1;
                out_beats_due.push_back(r);
            end
        end else begin
            foreach (passed[i]) begin
                r.data       = passed[i];
                r.has_byte   = 1'b1;
                r.run_last   = (i == passed.size() - 1);
                r.stream_end = (i == passed.size() - 1) && eos;
                out_beats_due.push_back(r);
            end
        end
    endfunction

    task flag_mismatch(string what);
        $display("MISMATCH: %s", what);
        errors++;
    endtask

    task match_beat(logic [7:0] data, logic has_byte, logic run_last, logic stream_end);
        cms_pkg::t_beat w;
        if (out_beats_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected beat data=%02h has=%0b last=%0b end=%0b",
                                    data, has_byte, run_last, stream_end));
            return;
        end
        w = out_beats_due.pop_front();
        if (data !== w.data || has_byte !== w.has_byte || run_last !== w.run_last ||
            stream_end !== w.stream_end) begin
            flag_mismatch($sformatf("got data=%02h has=%0b last=%0b end=%0b, want %02h %0b %0b %0b",
                                    data, has_byte, run_last, stream_end,
                                    w.data, w.has_byte, w.run_last, w.stream_end));
        end
    endtask

endclass

module cdata_marker_stripper_unit_tb;

    localparam int LONG_HOLD = 200;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       s_valid    = 1'b0;
    logic [7:0] s_data     = 8'h00;
    logic       s_last     = 1'b0;
    logic       m_ready    = 1'b1;
    wire logic  s_ready;
    wire logic  m_valid;
    wire logic [7:0] m_data;
    wire logic  m_last;
    wire logic [1:0] m_user;

    bit         src_idle_en  = 1'b1;
    bit         sink_idle_en = 1'b1;
    bit         hold_req     = 1'b0;
    int         bytes_taken  = 0;
    logic [7:0] doc_q[$];

    cdata_strip_tracker strip_sb = new();

    cdata_marker_stripper_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .o_m_axis_tuser  (m_user)
    );

    initial begin
        forever begin
            #5 clk = ~clk;
        end
    end

    initial begin
        #5000000;
        $display("cdata_marker_stripper_unit_tb: done, errors");
        $finish;
    end

    initial begin
        int burst;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                m_ready <= 1'b1;
            end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 7);
                m_ready <= 1'b0;
                repeat (burst) @(posedge clk);
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) begin
            strip_sb.match_beat(m_data, m_user[0], m_last, m_user[1]);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        int burst;
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= eos;
        do @(posedge clk); while (!s_ready);
        strip_sb.take_byte(b, eos);
        bytes_taken++;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 7);
            s_valid <= 1'b0;
            repeat (burst) @(posedge clk);
        end
    endtask

    task automatic send_doc();
        foreach (doc_q[i]) begin
            send_byte(doc_q[i], i == doc_q.size() - 1);
        end
        doc_q.delete();
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            doc_q.push_back(s[i]);
        end
    endtask

    task automatic push_open(input int len);
        logic [7:0] c;
        for (int i = 0; i < len; i++) begin
            c = cms_pkg::OPEN_PAT[i];
            if (c >= "a" && c <= "z" && $urandom_range(0, 1)) begin
                c = c & 8'hDF;
            end
            doc_q.push_back(c);
        end
    endtask

    task automatic push_close(input int len);
        for (int i = 0; i < len; i++) begin
            doc_q.push_back(cms_pkg::CLOSE_PAT[i]);
        end
    endtask

    task automatic build_random_doc();
        string near_marker;
        int    tokens;
        near_marker = "<![]>cdatCDAT!";
        tokens = $urandom_range(1, 14);
        repeat (tokens) begin
            case ($urandom_range(0, 9))
                0, 1: push_open(cms_pkg::OPEN_LEN);
                2, 3: push_close(cms_pkg::CLOSE_LEN);
                4: push_open($urandom_range(1, cms_pkg::OPEN_LEN - 1));
                5: push_close($urandom_range(1, cms_pkg::CLOSE_LEN - 1));
                6, 7: begin
                    repeat ($urandom_range(1, 4)) doc_q.push_back(8'($urandom_range(0, 255)));
                end
                8: doc_q.push_back(near_marker[$urandom_range(0, near_marker.len() - 1)]);
                default: begin
                    doc_q.push_back("<");
                    doc_q.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    initial begin
        int doc_n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_text("<![CdAtA[");
        doc_q.push_back(8'h00);
        doc_q.push_back(8'hFF);
        push_text("]]>");
        send_doc();
        push_text("]]><![c");
        send_doc();
        push_text("Q");
        send_doc();

        doc_n = 0;
        while (bytes_taken < 460) begin
            if (bytes_taken >= 390) begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end else if (doc_n == 4 || doc_n == 5) begin
                src_idle_en = 1'b0;
                if (doc_n == 4) begin
                    hold_req = 1'b1;
                end
            end else begin
                src_idle_en  = ($urandom_range(0, 3) != 0);
                sink_idle_en = ($urandom_range(0, 3) != 0);
            end
            if (doc_n == 12) begin
                s_valid <= 1'b0;
                while (strip_sb.pending() != 0) @(posedge clk);
            end
            build_random_doc();
            send_doc();
            doc_n++;
        end
        s_valid <= 1'b0;

        while (strip_sb.pending() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (strip_sb.errors == 0) begin
            $display("cdata_marker_stripper_unit_tb: done, clean");
        end else begin
            $display("cdata_marker_stripper_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
